[hw/rtl/speed_mode_selector_hysteresis_dwell_defines.svh]
// assertion macros for the speed mode selector
`ifndef SPEED_MODE_SELECTOR_HYSTERESIS_DWELL_DEFINES_SVH
`define SPEED_MODE_SELECTOR_HYSTERESIS_DWELL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define SMHD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define SMHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SMHD_ASSERT_IMPL(label, ante, cons, msg)
`define SMHD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[hw/rtl/smhd_pkg.sv]
// shared types and constants for the speed mode selector
`default_nettype none

package smhd_pkg;

  localparam int unsigned SpeedW   = 16;
  localparam int unsigned MsW      = 16;
  localparam int unsigned BandW    = 8;
  localparam int unsigned DwellW   = 16;
  localparam int unsigned NumThd   = 3;
  localparam int unsigned NumModes = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_TOWN     = 3'd1,
    MODE_COUNTRY  = 3'd2,
    MODE_MOTORWAY = 3'd3,
    MODE_WEATHER  = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLDS     = 3'd0,
    REG_HYSTERESIS     = 3'd1,
    REG_DWELL_NONE     = 3'd2,
    REG_DWELL_TOWN     = 3'd3,
    REG_DWELL_COUNTRY  = 3'd4,
    REG_DWELL_MOTORWAY = 3'd5,
    REG_DWELL_WEATHER  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [NumThd-1:0][SpeedW-1:0]   upper;
    logic [BandW-1:0]                band;
    logic [NumModes-1:0][DwellW-1:0] dwell;
  } cfg_t;

  typedef struct packed {
    logic [MsW-1:0]    elapsed_ms;
    logic [SpeedW-1:0] speed;
    logic              wiper_active;
    logic              function_active;
  } item_t;

  typedef struct packed {
    mode_e reported_mode;
    mode_e candidate_mode;
    logic  dwell_met;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/smhd_intf.sv]
// valid/ready channel interfaces for items, results and configuration writes
`default_nettype none

interface smhd_item_if;
  logic                              valid;
  logic                              ready;
  logic [smhd_pkg::MsW-1:0]          elapsed_ms;
  logic [smhd_pkg::SpeedW-1:0]       speed;
  logic                              wiper_active;
  logic                              function_active;
  modport source (output valid, elapsed_ms, speed, wiper_active, function_active,
                  input ready);
  modport sink (input valid, elapsed_ms, speed, wiper_active, function_active,
                output ready);
endinterface

interface smhd_result_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           reported_mode;
  logic [2:0]           candidate_mode;
  logic                 dwell_met;
  modport source (output valid, reported_mode, candidate_mode, dwell_met, input ready);
  modport sink (input valid, reported_mode, candidate_mode, dwell_met, output ready);
endinterface

interface smhd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [smhd_pkg::CfgIdxW-1:0]  index;
  logic [smhd_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/smhd_cfg_regs.sv]
// configuration register file: thresholds, hysteresis band and dwell times
`default_nettype none

module smhd_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [smhd_pkg::CfgIdxW-1:0]  wr_index_i,
  input  wire logic [smhd_pkg::CfgDataW-1:0] wr_data_i,
  output      smhd_pkg::cfg_t                cfg_o
);

  smhd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (smhd_pkg::cfg_idx_e'(wr_index_i))
        smhd_pkg::REG_THRESHOLDS:     cfg_d.upper    = wr_data_i[47:0];
        smhd_pkg::REG_HYSTERESIS:     cfg_d.band     = wr_data_i[7:0];
        smhd_pkg::REG_DWELL_NONE:     cfg_d.dwell[0] = wr_data_i[15:0];
        smhd_pkg::REG_DWELL_TOWN:     cfg_d.dwell[1] = wr_data_i[15:0];
        smhd_pkg::REG_DWELL_COUNTRY:  cfg_d.dwell[2] = wr_data_i[15:0];
        smhd_pkg::REG_DWELL_MOTORWAY: cfg_d.dwell[3] = wr_data_i[15:0];
        smhd_pkg::REG_DWELL_WEATHER:  cfg_d.dwell[4] = wr_data_i[15:0];
        default:                      cfg_d = cfg_q; // unused index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/smhd_mode_core.sv]
// mode selection state and single-pass update for one tick
`default_nettype none

module smhd_mode_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire smhd_pkg::cfg_t    cfg_i,
  input  wire smhd_pkg::item_t   item_i,
  input  wire logic              step_i,
  output      smhd_pkg::result_t result_o
);

  logic [smhd_pkg::SpeedW-1:0] last_speed_q, last_speed_d;
  logic                        started_q, started_d;
  smhd_pkg::mode_e             active_q, active_d;
  smhd_pkg::mode_e             pending_q, pending_d;
  logic [smhd_pkg::DwellW-1:0] count_q, count_d;
  logic                        done_q, done_d;

  logic                        restart;
  logic                        rise, fall;
  smhd_pkg::mode_e             up_pick, low_pick, cand;
  smhd_pkg::mode_e             pend_base, active_base;
  logic [smhd_pkg::DwellW-1:0] count_base;
  logic                        done_base;
  logic [smhd_pkg::DwellW:0]   sum;
  logic [smhd_pkg::DwellW-1:0] dwell_sel;
  logic [smhd_pkg::NumThd-1:0][smhd_pkg::SpeedW-1:0] lower;
  logic [smhd_pkg::SpeedW:0]   diff [smhd_pkg::NumThd];

  // falling-speed thresholds, floored at zero
  always_comb begin
    for (int k = 0; k < smhd_pkg::NumThd; k++) begin
      diff[k]  = {1'b0, cfg_i.upper[k]} - {{(smhd_pkg::SpeedW + 1 - smhd_pkg::BandW){1'b0}},
                                           cfg_i.band};
      lower[k] = diff[k][smhd_pkg::SpeedW] ? '0 : diff[k][smhd_pkg::SpeedW-1:0];
    end
  end

  always_comb begin
    priority if (item_i.speed >= cfg_i.upper[2]) up_pick = smhd_pkg::MODE_MOTORWAY;
    else if (item_i.speed >= cfg_i.upper[1])     up_pick = smhd_pkg::MODE_COUNTRY;
    else if (item_i.speed >= cfg_i.upper[0])     up_pick = smhd_pkg::MODE_TOWN;
    else                                         up_pick = smhd_pkg::MODE_NONE;

    priority if (item_i.speed < lower[0]) low_pick = smhd_pkg::MODE_NONE;
    else if (item_i.speed < lower[1])     low_pick = smhd_pkg::MODE_TOWN;
    else if (item_i.speed < lower[2])     low_pick = smhd_pkg::MODE_COUNTRY;
    else                                  low_pick = smhd_pkg::MODE_MOTORWAY;
  end

  always_comb begin
    restart = !started_q;
    rise    = (item_i.speed > last_speed_q) || restart;
    fall    = item_i.speed < last_speed_q;

    // a restart clears the timing state before the candidate is compared
    pend_base   = restart ? smhd_pkg::MODE_NONE : pending_q;
    active_base = restart ? smhd_pkg::MODE_NONE : active_q;
    count_base  = restart ? '0 : count_q;
    done_base   = restart ? 1'b0 : done_q;

    cand = pending_q;
    if (rise) cand = up_pick;
    if (fall) cand = low_pick;
    if ((cand > smhd_pkg::MODE_TOWN) && item_i.wiper_active) cand = smhd_pkg::MODE_WEATHER;

    sum = {1'b0, count_base} + {1'b0, item_i.elapsed_ms};
    if (cand != pend_base) begin
      pending_d = cand;
      count_d   = '0;
      done_d    = 1'b0;
    end else begin
      pending_d = pend_base;
      count_d   = sum[smhd_pkg::DwellW] ? '1 : sum[smhd_pkg::DwellW-1:0];
      done_d    = done_base;
    end

    unique case (pending_d)
      smhd_pkg::MODE_NONE:     dwell_sel = cfg_i.dwell[0];
      smhd_pkg::MODE_TOWN:     dwell_sel = cfg_i.dwell[1];
      smhd_pkg::MODE_COUNTRY:  dwell_sel = cfg_i.dwell[2];
      smhd_pkg::MODE_MOTORWAY: dwell_sel = cfg_i.dwell[3];
      smhd_pkg::MODE_WEATHER:  dwell_sel = cfg_i.dwell[4];
      default:                 dwell_sel = '1;
    endcase

    if (count_d >= dwell_sel) done_d = 1'b1;
    active_d     = done_d ? pending_d : active_base;
    started_d    = item_i.function_active;
    last_speed_d = item_i.speed;

    result_o.reported_mode  = item_i.function_active ? active_d : smhd_pkg::MODE_NONE;
    result_o.candidate_mode = pending_d;
    result_o.dwell_met      = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_speed_q <= '0;
      started_q    <= 1'b0;
      active_q     <= smhd_pkg::MODE_NONE;
      pending_q    <= smhd_pkg::MODE_NONE;
      count_q      <= '0;
      done_q       <= 1'b0;
    end else if (step_i) begin
      last_speed_q <= last_speed_d;
      started_q    <= started_d;
      active_q     <= active_d;
      pending_q    <= pending_d;
      count_q      <= count_d;
      done_q       <= done_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/speed_mode_selector_hysteresis_dwell.sv]
// Speed mode selector with hysteresis and dwell timing: top level.
//
// item_i carries one tick (elapsed_ms, speed, wiper_active, function_active);
// result_o returns one result per tick (reported_mode, candidate_mode,
// dwell_met) in order. cfg_i writes register index/data pairs; it is always
// ready and should only be used while no tick is in flight.
// A tick transfer lands in the input register; once the output stage is free
// the mode update runs in one pass and the result lands in the output register.
// Throughput is one tick per cycle while the receiver does not stall: the input
// register refills in the same cycle it drains.
// A stalled receiver holds the result register; the input register then
// holds its tick and ready drops only once both stages are full.
// Reset clears all configuration registers and the mode state (restart
// pending, modes none, dwell counter zero) and empties both stages.
`default_nettype none
`include "speed_mode_selector_hysteresis_dwell_defines.svh"

module speed_mode_selector_hysteresis_dwell (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  smhd_item_if.sink   item_i,
  smhd_cfg_if.sink    cfg_i,
  smhd_result_if.source result_o
);

  smhd_pkg::cfg_t    cfg;
  smhd_pkg::item_t   in_q;
  logic              in_valid_q;
  smhd_pkg::result_t res;
  smhd_pkg::result_t out_q;
  logic              out_valid_q;
  logic              advance;
  logic              in_ready;

  assign cfg_i.ready = 1'b1;

  smhd_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // the tick in the input register moves on when the output stage is free
  assign advance  = in_valid_q && (!out_valid_q || result_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign item_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && item_i.valid) begin
      in_q.elapsed_ms      <= item_i.elapsed_ms;
      in_q.speed           <= item_i.speed;
      in_q.wiper_active    <= item_i.wiper_active;
      in_q.function_active <= item_i.function_active;
    end
  end

  smhd_mode_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg),
    .item_i   (in_q),
    .step_i   (advance),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.reported_mode  = out_q.reported_mode;
  assign result_o.candidate_mode = out_q.candidate_mode;
  assign result_o.dwell_met      = out_q.dwell_met;

  // a met dwell means the active mode is the candidate, unless reported as none
  `SMHD_ASSERT_IMPL(a_met_reports_candidate, out_valid_q && out_q.dwell_met,
    out_q.reported_mode == out_q.candidate_mode ||
    out_q.reported_mode == smhd_pkg::MODE_NONE, "dwell met but mode not taken")
  `SMHD_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_q,
    "advanced tick did not reach the result register")
  `SMHD_ASSERT_NEXT(a_stall_keeps_input, in_valid_q && out_valid_q && !result_o.ready,
    in_valid_q, "tick lost while the receiver stalls")

endmodule

`default_nettype wire
